// ----- hdl/tlprb_pkg.sv -----
// Package for the two-level priority ready bitmap.
// Holds the operation and error codes, the stream field widths and the
// lowest-set-bit helper. No dependencies.
package tlprb_pkg;

    // Fixed widths of the item fields
    localparam int KIND_W      = 2;
    localparam int CPU_W       = 3;
    localparam int CLASS_W     = 6;
    localparam int ERR_W       = 2;
    localparam int OUT_CNT_W   = 16;
    localparam int GRP_W       = 8;
    localparam int GROUP_SEL_W = 3;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_PICK = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_DEQ_EMPTY = 2'd1,
        ERR_ENQ_FULL  = 2'd2,
        ERR_RSVD      = 2'd3
    } err_t;

    // Index of the lowest set bit of an 8-bit mask; 7 when the mask is zero
    function automatic logic [GROUP_SEL_W-1:0] low_bit8(input logic [GRP_W-1:0] v);
        logic [GROUP_SEL_W-1:0] idx;
        idx = GROUP_SEL_W'(GRP_W - 1);
        for (int i = GRP_W - 2; i >= 0; i--) begin
            if (v[i]) begin
                idx = GROUP_SEL_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- hdl/two_level_priority_ready_bitmap_top.sv -----
// Top level of the two-level priority ready bitmap: per-CPU run queue tracker.
// Depends on tlprb_pkg for codes, field widths and the lowest-set-bit helper.
//
// Usage:
//   The input channel (s_axis_*) takes one operation per item: enqueue a
//   task into a class, dequeue a task from a class, or pick the lowest
//   numbered ready class of a CPU. Every item gives exactly one result on
//   the output channel (m_axis_*) with the picked or addressed class, a
//   none-ready flag, an error code and the class's task count afterwards.
//   An accepted item sits in the input register, and its result then moves
//   into the result register that drives m_axis_*.
//   Throughput is one item per cycle while the receiver does not stall, set
//   by the single read-modify-write of the per-CPU count row, which is read
//   at accept time and written back as the item moves into the result
//   register; a bypass register covers a back-to-back item on the same CPU.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; then s_axis_tready drops.
//   Reset empties both registers and clears every mask and the per-row
//   valid bits, so all counts read as zero at once; there is no
//   clearing pass and the block takes items right after reset.
module two_level_priority_ready_bitmap_top
    import tlprb_pkg::*;
#(
    parameter int NUM_CPUS   = 8,
    parameter int NUM_LEVELS = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input item channel
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [2:0] cpu, [8:3] class, [15:9] zero
    input  logic [KIND_W-1:0]    s_axis_tuser,   // [1:0] kind
    // Result item channel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [5:0] picked_class, [7:6] error_code,
                                                 // [23:8] class_count
    output logic                 m_axis_tuser    // [0] none_ready
);

    localparam int CPU_IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int LVL_IDX_W = $clog2(NUM_LEVELS);

    typedef logic [NUM_LEVELS-1:0][COUNT_BITS-1:0] cnt_row_t;

    // Handshake and pipeline control
    logic s_accept;
    logic advance;
    logic in_vld_reg;
    logic out_vld_reg;

    // Input register
    kind_t              in_kind_reg;
    logic [CPU_W-1:0]   in_cpu_reg;
    logic [CLASS_W-1:0] in_cls_reg;
    logic [CPU_W-1:0]   in_cpu_next;

    // Count store: one row of counts per CPU, valid bits per row
    cnt_row_t             cnt_mem [NUM_CPUS];
    cnt_row_t             rd_row_reg;
    cnt_row_t             byp_row_reg;
    logic                 byp_vld_reg;
    logic [NUM_CPUS-1:0]  row_vld_reg;
    logic [CPU_IDX_W-1:0] rd_idx;

    // Ready masks
    logic [GRP_W-1:0]      grp_ready_reg [NUM_CPUS];
    logic [NUM_LEVELS-1:0] lvl_ready_reg [NUM_CPUS];

    // Stage logic
    logic                  cpu_ok;
    logic                  cls_ok;
    logic [CPU_IDX_W-1:0]  cpu_idx;
    logic [LVL_IDX_W-1:0]  cls_idx;
    cnt_row_t              cur_row;
    cnt_row_t              new_row;
    logic [GRP_W-1:0]      grp_cur;
    logic [NUM_LEVELS-1:0] lvl_cur;
    logic [GRP_W-1:0]      grp_new;
    logic [NUM_LEVELS-1:0] lvl_new;
    logic [63:0]           lvl_wide;
    logic [63:0]           lvl_new_wide;
    logic [GROUP_SEL_W-1:0] pick_grp;
    logic [GRP_W-1:0]      pick_bits;
    logic [CLASS_W-1:0]    pick_cls;
    logic [COUNT_BITS-1:0] cnt_old;
    logic [COUNT_BITS-1:0] cnt_new;
    logic                  wr_en;
    logic [GRP_W-1:0]      grp_from_lvl;

    // Result values
    logic [CLASS_W-1:0]    res_cls;
    logic                  res_none;
    err_t                  res_err;
    logic [COUNT_BITS-1:0] res_cnt;

    // Result register
    logic [CLASS_W-1:0]   out_cls_reg;
    logic                 out_none_reg;
    err_t                 out_err_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;

    // Two-register flow: the input register passes its item on whenever the result register can take it
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Address the count row of the item that will sit in the input register
    assign in_cpu_next = s_accept ? s_axis_tdata[CPU_W-1:0] : in_cpu_reg;
    assign rd_idx      = (int'(in_cpu_next) < NUM_CPUS) ? CPU_IDX_W'(in_cpu_next) : '0;

    // Decode the held item
    assign cpu_ok  = int'(in_cpu_reg) < NUM_CPUS;
    assign cls_ok  = int'(in_cls_reg) < NUM_LEVELS;
    assign cpu_idx = cpu_ok ? CPU_IDX_W'(in_cpu_reg) : '0;
    assign cls_idx = cls_ok ? LVL_IDX_W'(in_cls_reg) : '0;

    // Pick the freshest copy of the row: just written, stored, or never written
    always_comb begin
        if (byp_vld_reg) begin
            cur_row = byp_row_reg;
        end else if (row_vld_reg[cpu_idx]) begin
            cur_row = rd_row_reg;
        end else begin
            cur_row = '0;
        end
    end

    assign grp_cur  = grp_ready_reg[cpu_idx];
    assign lvl_cur  = lvl_ready_reg[cpu_idx];
    assign lvl_wide = 64'(lvl_cur);
    assign cnt_old  = cur_row[cls_idx];

    // Find the lowest ready group, then the lowest ready class inside it
    assign pick_grp  = low_bit8(grp_cur);
    assign pick_bits = (grp_cur != '0) ? lvl_wide[{pick_grp, 3'b000} +: GRP_W] : '0;
    assign pick_cls  = {pick_grp, low_bit8(pick_bits)};

    // Work out the update and the result of the held item
    always_comb begin
        res_cls      = in_cls_reg;
        res_none     = 1'b0;
        res_err      = ERR_OK;
        res_cnt      = '0;
        cnt_new      = cnt_old;
        new_row      = cur_row;
        lvl_new      = lvl_cur;
        lvl_new_wide = '0;
        grp_new      = grp_cur;
        wr_en        = 1'b0;
        if (!cpu_ok) begin
            res_none = (in_kind_reg == KIND_PICK);
        end else begin
            unique case (in_kind_reg)
                KIND_PICK: begin
                    if (pick_bits == '0 || int'(pick_cls) >= NUM_LEVELS) begin
                        res_none = 1'b1;
                        res_cls  = '0;
                    end else begin
                        res_cls = pick_cls;
                        res_cnt = cur_row[LVL_IDX_W'(pick_cls)];
                    end
                end
                KIND_ENQ: begin
                    if (cls_ok) begin
                        wr_en = 1'b1;
                        if (cnt_old == '1) begin
                            res_err = ERR_ENQ_FULL;
                        end else begin
                            cnt_new = cnt_old + COUNT_BITS'(1);
                        end
                        lvl_new[cls_idx]                       = 1'b1;
                        grp_new[in_cls_reg[CLASS_W-1 -: 3]]     = 1'b1;
                        new_row[cls_idx]                       = cnt_new;
                        res_cnt                                = cnt_new;
                    end
                end
                KIND_DEQ: begin
                    if (cls_ok) begin
                        wr_en = 1'b1;
                        if (cnt_old == '0) begin
                            res_err = ERR_DEQ_EMPTY;
                        end else begin
                            cnt_new = cnt_old - COUNT_BITS'(1);
                            if (cnt_new == '0) begin
                                lvl_new[cls_idx] = 1'b0;
                                lvl_new_wide     = 64'(lvl_new);
                                if (lvl_new_wide[{in_cls_reg[CLASS_W-1 -: 3], 3'b000} +: 8]
                                        == '0) begin
                                    grp_new[in_cls_reg[CLASS_W-1 -: 3]] = 1'b0;
                                end
                            end
                        end
                        new_row[cls_idx] = cnt_new;
                        res_cnt          = cnt_new;
                    end
                end
                default: begin
                    res_none = 1'b0;
                end
            endcase
        end
    end

    // Count store: write back the row, read the next one, keep a bypass copy
    always_ff @(posedge aclk) begin
        if (advance && wr_en) begin
            cnt_mem[cpu_idx] <= new_row;
        end
        rd_row_reg  <= cnt_mem[rd_idx];
        byp_row_reg <= new_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_vld_reg <= 1'b0;
            row_vld_reg <= '0;
        end else begin
            byp_vld_reg <= advance && wr_en && (cpu_idx == rd_idx);
            if (advance && wr_en) begin
                row_vld_reg[cpu_idx] <= 1'b1;
            end
        end
    end

    // Ready masks: commit as the item leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CPUS; i++) begin
                grp_ready_reg[i] <= '0;
                lvl_ready_reg[i] <= '0;
            end
        end else if (advance && wr_en) begin
            grp_ready_reg[cpu_idx] <= grp_new;
            lvl_ready_reg[cpu_idx] <= lvl_new;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_accept) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg <= kind_t'(s_axis_tuser);
            in_cpu_reg  <= s_axis_tdata[CPU_W-1:0];
            in_cls_reg  <= s_axis_tdata[CPU_W +: CLASS_W];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_cls_reg  <= res_cls;
            out_none_reg <= res_none;
            out_err_reg  <= res_err;
            out_cnt_reg  <= OUT_CNT_W'(res_cnt);
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_cnt_reg, out_err_reg, out_cls_reg};
    assign m_axis_tuser  = out_none_reg;

    // Group bits rebuilt from the level mask of the addressed CPU
    always_comb begin
        grp_from_lvl = '0;
        for (int g = 0; g < GRP_W; g++) begin
            grp_from_lvl[g] = |lvl_wide[g*8 +: 8];
        end
    end

    // A group bit is set exactly when one of its classes is ready
    a_grp_matches_lvl: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && cpu_ok |-> grp_cur == grp_from_lvl)
        else $error("group mask out of step with level mask");

    // A failed dequeue always reports a zero count
    a_deq_empty_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_err_reg == ERR_DEQ_EMPTY |-> out_cnt_reg == '0)
        else $error("dequeue error with nonzero count");

    // An empty pick carries no error and no count
    a_none_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_none_reg |-> out_err_reg == ERR_OK && out_cnt_reg == '0)
        else $error("none-ready result with error or count");

    // The input register drains when it advances and nothing new arrives
    a_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !s_accept |=> !in_vld_reg)
        else $error("input register kept a delivered item");

    // The bypass copy is only live right after a write-back
    a_byp_after_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_vld_reg |-> $past(advance && wr_en))
        else $error("bypass valid without a write-back");

endmodule

// ----- tb/tb_two_level_priority_ready_bitmap_top.sv -----
// Testbench for two_level_priority_ready_bitmap_top: enqueue, dequeue and pick items
// are checked against a per-CPU run queue tracker kept in the bench itself.
// Depends on tlprb_pkg for the operation and error codes and the stream widths.
`timescale 1ns / 1ps

module tb_two_level_priority_ready_bitmap_top
    import tlprb_pkg::*;
();

    localparam int CPUS           = 8;
    localparam int LEVELS         = 64;
    localparam int RANDOM_OPS     = 240;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_SHOWN      = 10;
    localparam logic [15:0] COUNT_TOP = 16'hffff;

    // One result item, unpacked from m_axis_tdata and m_axis_tuser
    typedef struct packed {
        logic [5:0]  cls;
        logic        none;
        err_t        err;
        logic [15:0] cnt;
    } sched_res_t;

    // One row of the directed table; pinned rows carry a typed-in result
    typedef struct {
        kind_t       op;
        int unsigned cpu;
        int unsigned cls;
        int unsigned reps;
        bit          pinned;
        sched_res_t  res;
    } op_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [KIND_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // Tracker state mirrored by the bench
    logic [7:0]  grp_mask_m [CPUS];
    logic [63:0] level_mask [CPUS];
    logic [15:0] task_cnt   [CPUS][LEVELS];

    sched_res_t  pending_q[$];
    op_row_t     op_rows[24];
    int          src_idle_pct;
    int          snk_idle_pct;
    int          idle_cycles;
    int          mismatches;
    int          n_enq, n_deq, n_pick, n_nop, n_full, n_deq_empty, n_none;

    two_level_priority_ready_bitmap_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one operation to the mirrored tracker and return its result
    function automatic sched_res_t track_op(kind_t k, logic [2:0] c, logic [5:0] cl);
        sched_res_t  r;
        logic [7:0]  lvl_byte;
        int          grp;
        int          lvl;
        r = '{cls: cl, none: 1'b0, err: ERR_OK, cnt: 16'd0};
        case (k)
            KIND_ENQ: begin
                n_enq++;
                if (task_cnt[c][cl] == COUNT_TOP) begin
                    r.err = ERR_ENQ_FULL;
                    n_full++;
                end else begin
                    task_cnt[c][cl] = task_cnt[c][cl] + 16'd1;
                end
                level_mask[c][cl] = 1'b1;
                grp_mask_m[c][cl[5:3]] = 1'b1;
                r.cnt = task_cnt[c][cl];
            end
            KIND_DEQ: begin
                n_deq++;
                if (task_cnt[c][cl] == 16'd0) begin
                    r.err = ERR_DEQ_EMPTY;
                    n_deq_empty++;
                end else begin
                    task_cnt[c][cl] = task_cnt[c][cl] - 16'd1;
                    // Drop the class bit at zero, and the group bit once its byte is empty
                    if (task_cnt[c][cl] == 16'd0) begin
                        level_mask[c][cl] = 1'b0;
                        if (level_mask[c][cl[5:3]*8 +: 8] == 8'd0) begin
                            grp_mask_m[c][cl[5:3]] = 1'b0;
                        end
                    end
                end
                r.cnt = task_cnt[c][cl];
            end
            KIND_PICK: begin
                n_pick++;
                grp = -1;
                lvl = -1;
                for (int g = 7; g >= 0; g--) begin
                    if (grp_mask_m[c][g]) grp = g;
                end
                if (grp >= 0) begin
                    lvl_byte = level_mask[c][grp*8 +: 8];
                    for (int b = 7; b >= 0; b--) begin
                        if (lvl_byte[b]) lvl = b;
                    end
                end
                if (lvl < 0) begin
                    r.none = 1'b1;
                    r.cls  = 6'd0;
                    n_none++;
                end else begin
                    r.cls = 6'(grp * 8 + lvl);
                    r.cnt = task_cnt[c][grp * 8 + lvl];
                end
            end
            default: begin
                n_nop++;
            end
        endcase
        return r;
    endfunction

    // Predict one item, queue its result, then present it until accepted
    task automatic issue_op(kind_t k, logic [2:0] c, logic [5:0] cl, bit pinned,
                            sched_res_t pinned_res);
        sched_res_t r;
        r = track_op(k, c, cl);
        pending_q.push_back(pinned ? pinned_res : r);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, cl, c};
        s_axis_tuser  <= k;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly well-formed traffic: dequeues chase classes that hold tasks
    task automatic run_random(int n_ops);
        int          done;
        int          r;
        int          idx;
        bit          found;
        kind_t       k;
        logic [2:0]  c;
        logic [5:0]  cl;
        done = 0;
        while (done < n_ops) begin
            r  = $urandom_range(0, 99);
            c  = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 1))
                                              : 3'($urandom_range(0, 7));
            cl = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 15))
                                              : 6'($urandom_range(0, 63));
            if (r < 40)      k = KIND_ENQ;
            else if (r < 72) k = KIND_DEQ;
            else if (r < 96) k = KIND_PICK;
            else             k = KIND_NOP;
            if (k == KIND_DEQ && $urandom_range(0, 99) < 75) begin
                found = 1'b0;
                for (int i = 0; i < LEVELS; i++) begin
                    idx = (int'(cl) + i) % LEVELS;
                    if (!found && task_cnt[c][idx] != 16'd0) begin
                        cl    = 6'(idx);
                        found = 1'b1;
                    end
                end
            end
            issue_op(k, c, cl, 1'b0, '0);
            if (k != KIND_NOP) done++;
        end
    endtask

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("%0t: %s", $realtime, msg);
    endtask

    // Receiver: stall at random at the falling edge
    always @(negedge aclk) begin
        if (aresetn) m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Compare each accepted result with the oldest pending one; track progress
    always @(posedge aclk) begin
        sched_res_t got;
        sched_res_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.cls  = m_axis_tdata[5:0];
                got.err  = err_t'(m_axis_tdata[7:6]);
                got.cnt  = m_axis_tdata[23:8];
                got.none = m_axis_tuser;
                if (pending_q.size() == 0) begin
                    note_mismatch($sformatf(
                        "unexpected result cls=%0d none=%0b err=%0d cnt=%0d",
                        got.cls, got.none, got.err, got.cnt));
                end else begin
                    want = pending_q.pop_front();
                    if (got.cls !== want.cls || got.none !== want.none ||
                        got.err !== want.err || got.cnt !== want.cnt) begin
                        note_mismatch({
                            $sformatf("result mismatch: exp cls=%0d none=%0b err=%0d cnt=%0d,",
                                      want.cls, want.none, want.err, want.cnt),
                            $sformatf(" got cls=%0d none=%0b err=%0d cnt=%0d",
                                      got.cls, got.none, got.err, got.cnt)});
                    end
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // End the run if nothing moves for too long
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("two_level_priority_ready_bitmap_top test failed");
        $finish;
    end

    // Main sequence: reset, directed table, three random phases, drain
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        idle_cycles   = 0;
        mismatches    = 0;
        {n_enq, n_deq, n_pick, n_nop, n_full, n_deq_empty, n_none} = '0;
        for (int c = 0; c < CPUS; c++) begin
            grp_mask_m[c] = '0;
            level_mask[c] = '0;
            for (int l = 0; l < LEVELS; l++) task_cnt[c][l] = '0;
        end

        // Empty tracker, single class, group sharing, kind three, repeated enqueue
        op_rows = '{
            '{KIND_PICK, 0, 0,  1, 1'b1, '{6'd0,  1'b1, ERR_OK,        16'd0}},
            '{KIND_DEQ,  0, 0,  1, 1'b1, '{6'd0,  1'b0, ERR_DEQ_EMPTY, 16'd0}},
            '{KIND_ENQ,  0, 63, 1, 1'b1, '{6'd63, 1'b0, ERR_OK,        16'd1}},
            '{KIND_PICK, 0, 17, 1, 1'b1, '{6'd63, 1'b0, ERR_OK,        16'd1}},
            '{KIND_ENQ,  0, 0,  1, 1'b1, '{6'd0,  1'b0, ERR_OK,        16'd1}},
            '{KIND_PICK, 0, 0,  1, 1'b1, '{6'd0,  1'b0, ERR_OK,        16'd1}},
            '{KIND_ENQ,  0, 0,  1, 1'b0, '0},
            '{KIND_DEQ,  0, 0,  1, 1'b0, '0},
            '{KIND_DEQ,  0, 0,  1, 1'b0, '0},
            '{KIND_PICK, 0, 0,  1, 1'b0, '0},
            '{KIND_ENQ,  0, 9,  1, 1'b0, '0},
            '{KIND_ENQ,  0, 10, 1, 1'b0, '0},
            '{KIND_DEQ,  0, 9,  1, 1'b0, '0},
            '{KIND_PICK, 0, 0,  1, 1'b0, '0},
            '{KIND_DEQ,  0, 10, 1, 1'b0, '0},
            '{KIND_PICK, 0, 0,  1, 1'b0, '0},
            '{KIND_NOP,  5, 42, 1, 1'b1, '{6'd42, 1'b0, ERR_OK,        16'd0}},
            '{KIND_PICK, 7, 37, 1, 1'b1, '{6'd0,  1'b1, ERR_OK,        16'd0}},
            '{KIND_ENQ,  7, 56, 3, 1'b0, '0},
            '{KIND_ENQ,  7, 56, 1, 1'b1, '{6'd56, 1'b0, ERR_OK,        16'd4}},
            '{KIND_PICK, 7, 0,  1, 1'b1, '{6'd56, 1'b0, ERR_OK,        16'd4}},
            '{KIND_DEQ,  7, 56, 1, 1'b0, '0},
            '{KIND_DEQ,  0, 63, 1, 1'b0, '0},
            '{KIND_PICK, 0, 0,  1, 1'b1, '{6'd0,  1'b1, ERR_OK,        16'd0}}
        };

        src_idle_pct = 21;
        snk_idle_pct = 68;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (op_rows[i]) begin
            for (int n = 0; n < op_rows[i].reps; n++) begin
                issue_op(op_rows[i].op, 3'(op_rows[i].cpu), 6'(op_rows[i].cls),
                         op_rows[i].pinned, op_rows[i].res);
            end
        end
        run_random(RANDOM_OPS);

        src_idle_pct = 68;
        snk_idle_pct = 21;
        run_random(RANDOM_OPS);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(RANDOM_OPS);
        s_axis_tvalid <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d enqueues (%0d saturated), %0d dequeues (%0d on empty class),",
                 n_enq, n_full, n_deq, n_deq_empty);
        $display("%0d picks (%0d with nothing ready), %0d idle-kind items, %0d mismatches",
                 n_pick, n_none, n_nop, mismatches);
        if (mismatches == 0) begin
            $display("two_level_priority_ready_bitmap_top test passed");
        end else begin
            $display("two_level_priority_ready_bitmap_top test failed");
        end
        $finish;
    end

endmodule

// ----- two_level_priority_ready_bitmap_top.f -----
hdl/tlprb_pkg.sv
hdl/two_level_priority_ready_bitmap_top.sv
tb/tb_two_level_priority_ready_bitmap_top.sv
